// ===== rtl/etfc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package etfc_pkg;

    // Field widths
    localparam int CW  = 32;            // coordinate, signed Q16.16
    localparam int DW  = 34;            // exact edge difference
    localparam int VW  = 63;            // widest vector fed to the unitizer
    localparam int RW  = 31;            // radius register width

    // Edge queue between front and back
    localparam int QDEPTH = 2;          // power of two, pointers wrap freely
    localparam int QAW    = 1;
    localparam int QCW    = QAW + 1;

    // Fixed-point constants
    localparam logic [31:0]        ONE_Q30   = 32'h4000_0000;
    localparam logic signed [31:0] PAR_LIMIT = 32'sh3FFF_FF80;
    localparam logic [RW-1:0]      RADIUS_RESET = 31'd6554;

    // Register indexes
    localparam logic [1:0] CFG_RADIUS_SIDE = 2'd0;
    localparam logic [1:0] CFG_RADIUS_UP   = 2'd1;
    localparam logic [1:0] CFG_AXIAL       = 2'd2;

    localparam logic [1:0] CORNER_LAST = 2'd3;

    typedef logic [2:0][VW-1:0] t_wvec;
    typedef logic [2:0][CW-1:0] t_uvec;

    typedef struct packed {
        logic [2:0][CW-1:0] p;
        logic [2:0][DW-1:0] d;
        logic               join_prev;
    } t_edge;

    typedef struct packed {
        logic [RW-1:0] radius_side;
        logic [RW-1:0] radius_up;
        logic [CW-1:0] axial_offset;
    } t_cfg;

endpackage

`default_nettype wire

// ===== rtl/etfc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module etfc_front
    import etfc_pkg::*;
(
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [191:0] i_s_axis_tdata,
    input  logic [0:0]   i_s_axis_tuser,
    input  logic         i_q_full,
    output logic         o_q_push,
    output t_edge        o_q_item
);

    logic [CW-1:0] start_c;
    logic [CW-1:0] end_c;

    // Accept whenever the queue has room
    assign o_s_axis_tready = !i_q_full;
    assign o_q_push        = i_s_axis_tvalid && !i_q_full;

    // Split the item and form the exact edge difference
    always_comb begin
        o_q_item.join_prev = ~i_s_axis_tuser[0];
        for (int i = 0; i < 3; i++) begin
            start_c = i_s_axis_tdata[CW*i +: CW];
            end_c   = i_s_axis_tdata[CW*(3+i) +: CW];
            o_q_item.p[i] = start_c;
            o_q_item.d[i] = {{(DW-CW){end_c[CW-1]}}, end_c}
                          - {{(DW-CW){start_c[CW-1]}}, start_c};
        end
    end

endmodule

`default_nettype wire

// ===== rtl/etfc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module etfc_queue
    import etfc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_edge i_item,
    output logic  o_full,
    input  logic  i_pop,
    output t_edge o_item,
    output logic  o_empty
);

    t_edge           r_mem [QDEPTH];
    logic [QAW-1:0]  r_wr;
    logic [QAW-1:0]  r_rd;
    logic [QCW-1:0]  r_count;

    assign o_full  = (r_count == QCW'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd];

    // Store the item
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/etfc_unitize.sv =====
`timescale 1ns / 1ps
`default_nettype none

module etfc_unitize
    import etfc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_wvec i_v,
    output logic  o_done,
    output t_uvec o_u
);

    typedef enum logic [6:0] {
        U_IDLE  = 7'b0000001,
        U_MAX   = 7'b0000010,
        U_NORM  = 7'b0000100,
        U_SQ    = 7'b0001000,
        U_ROOT  = 7'b0010000,
        U_DLOAD = 7'b0100000,
        U_DIV   = 7'b1000000
    } t_ustate;

    t_ustate            r_state;
    logic [2:0][VW-1:0] r_mag;
    logic [2:0]         r_neg;
    logic [VW-1:0]      r_m;
    logic [4:0]         r_cnt;
    logic [1:0]         r_k;
    logic [61:0]        r_prod;
    logic [63:0]        r_acc;
    logic [63:0]        r_n;
    logic [63:0]        r_r;
    logic [31:0]        r_rem;
    logic [31:0]        r_num;
    logic [31:0]        r_q;
    t_uvec              r_u;
    logic               r_done;

    logic [2:0][VW-1:0] in_mag;
    logic [VW-1:0]      max01;
    logic [VW-1:0]      max012;
    logic [63:0]        root_bit;
    logic [63:0]        root_try;
    logic [31:0]        len;
    logic [61:0]        div_num;
    logic [32:0]        div_try;
    logic [32:0]        div_diff;
    logic               div_bit;
    logic [31:0]        q_full;
    logic [31:0]        q_clip;
    logic [31:0]        q_neg;

    // Magnitudes of the incoming vector
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_mag[i] = i_v[i][VW-1] ? (~i_v[i] + 1'b1) : i_v[i];
        end
    end

    assign max01  = (r_mag[0] > r_mag[1]) ? r_mag[0] : r_mag[1];
    assign max012 = (max01 > r_mag[2]) ? max01 : r_mag[2];

    // One square-root digit per cycle
    assign len      = r_r[31:0];
    assign root_bit = 64'd1 << {r_cnt, 1'b0};
    assign root_try = r_r + root_bit;

    // One quotient bit per cycle, rounded numerator
    assign div_num  = {1'b0, r_mag[r_k][30:0], 30'd0} + {31'd0, len[31:1]};
    assign div_try  = {r_rem, r_num[31]};
    assign div_diff = div_try - {1'b0, len};
    assign div_bit  = (div_try >= {1'b0, len});
    assign q_full   = {r_q[30:0], div_bit};
    assign q_clip   = (q_full > ONE_Q30) ? ONE_Q30 : q_full;
    assign q_neg    = ~q_clip + 1'b1;

    assign o_done = r_done;
    assign o_u    = r_u;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                U_IDLE: begin
                    if (i_start) begin
                        r_mag   <= in_mag;
                        r_neg   <= {i_v[2][VW-1], i_v[1][VW-1], i_v[0][VW-1]};
                        r_state <= U_MAX;
                    end
                end
                U_MAX: begin
                    r_m <= max012;
                    if (max012 == '0) begin
                        r_u     <= '0;
                        r_done  <= 1'b1;
                        r_state <= U_IDLE;
                    end else begin
                        r_state <= U_NORM;
                    end
                end
                // Bring the largest magnitude into [2^30, 2^31)
                U_NORM: begin
                    if (r_m[VW-1:31] != '0) begin
                        for (int i = 0; i < 3; i++) begin
                            r_mag[i] <= r_mag[i] >> 1;
                        end
                        r_m <= r_m >> 1;
                    end else if (!r_m[30]) begin
                        for (int i = 0; i < 3; i++) begin
                            r_mag[i] <= r_mag[i] << 1;
                        end
                        r_m <= r_m << 1;
                    end else begin
                        r_cnt   <= '0;
                        r_acc   <= '0;
                        r_state <= U_SQ;
                    end
                end
                // Sum of squares through one multiplier
                U_SQ: begin
                    if (r_cnt[1:0] != 2'd3) begin
                        r_prod <= r_mag[r_cnt[1:0]][30:0] * r_mag[r_cnt[1:0]][30:0];
                    end
                    if (r_cnt[1:0] == 2'd3) begin
                        r_n     <= r_acc + {2'd0, r_prod};
                        r_r     <= '0;
                        r_cnt   <= 5'd31;
                        r_state <= U_ROOT;
                    end else begin
                        if (r_cnt[1:0] != 2'd0) begin
                            r_acc <= r_acc + {2'd0, r_prod};
                        end
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                U_ROOT: begin
                    if (r_n >= root_try) begin
                        r_n <= r_n - root_try;
                        r_r <= (r_r >> 1) + root_bit;
                    end else begin
                        r_r <= r_r >> 1;
                    end
                    if (r_cnt == '0) begin
                        r_k     <= '0;
                        r_state <= U_DLOAD;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                U_DLOAD: begin
                    r_rem   <= {2'd0, div_num[61:32]};
                    r_num   <= div_num[31:0];
                    r_cnt   <= 5'd31;
                    r_state <= U_DIV;
                end
                U_DIV: begin
                    r_rem <= div_bit ? div_diff[31:0] : div_try[31:0];
                    r_num <= r_num << 1;
                    r_q   <= q_full;
                    if (r_cnt == '0) begin
                        r_u[r_k] <= r_neg[r_k] ? q_neg : q_clip;
                        if (r_k == 2'd2) begin
                            r_done  <= 1'b1;
                            r_state <= U_IDLE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= U_DLOAD;
                        end
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                default: begin
                    r_state <= U_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/etfc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module etfc_back
    import etfc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_q_empty,
    output logic        o_q_pop,
    input  t_edge       i_q_item,
    output logic        o_u_start,
    output t_wvec       o_u_vec,
    input  logic        i_u_done,
    input  t_uvec       i_u_res,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [95:0] o_m_axis_tdata,
    output logic [2:0]  o_m_axis_tuser,
    output logic        o_m_axis_tlast
);

    typedef enum logic [6:0] {
        B_IDLE  = 7'b0000001,
        B_UX    = 7'b0000010,
        B_UY    = 7'b0000100,
        B_CROSS = 7'b0001000,
        B_UZ    = 7'b0010000,
        B_SCALE = 7'b0100000,
        B_EMIT  = 7'b1000000
    } t_bstate;

    t_bstate            r_state;
    logic               r_start;
    t_wvec              r_uvec;
    t_uvec              r_p;
    logic               r_join;
    t_uvec              r_ux;
    t_uvec              r_uy;
    t_uvec              r_uz;
    logic [2:0][VW-1:0] r_w;
    logic [3:0]         r_cnt;
    logic signed [63:0] r_mprod;
    logic [62:0]        r_sprod;
    logic               r_sneg;
    logic signed [33:0] r_scl [9];
    logic [1:0]         r_k;
    logic               r_ovalid;
    logic [95:0]        r_odata;
    logic [2:0]         r_ouser;
    logic               r_olast;

    logic               is_general;
    logic               out_free;
    logic signed [31:0] c_a;
    logic signed [31:0] c_b;
    logic signed [63:0] c_prod;
    logic [2:0]         c_j;
    logic [1:0]         s_vec;
    logic [1:0]         s_comp;
    logic [31:0]        s_u;
    logic [32:0]        s_r;
    logic [31:0]        s_un;
    logic [32:0]        s_rn;
    logic [30:0]        s_ua;
    logic [31:0]        s_ra;
    logic [62:0]        s_round;
    logic [33:0]        s_mag;
    logic [33:0]        s_val;
    logic               sy;
    logic               sz;
    logic signed [35:0] e_sum;
    logic [95:0]        corner;

    function automatic logic [31:0] sat32(input logic signed [35:0] v);
        logic [31:0] res;
        if (v[35:31] == 5'b00000 || v[35:31] == 5'b11111) begin
            res = v[31:0];
        end else begin
            res = v[35] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return res;
    endfunction

    assign o_q_pop   = (r_state == B_IDLE) && !i_q_empty;
    assign o_u_start = r_start;
    assign o_u_vec   = r_uvec;
    assign out_free  = !r_ovalid || i_m_axis_tready;

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;
    assign o_m_axis_tlast  = r_olast;

    // Direction near world Z selects the fixed frame
    assign is_general = ($signed(i_u_res[2]) > -PAR_LIMIT)
                     && ($signed(i_u_res[2]) < PAR_LIMIT);

    // Cross product operand order: x, y, z terms in pairs
    always_comb begin
        case (r_cnt[2:0])
            3'd0:    begin c_a = r_ux[1]; c_b = r_uy[2]; end
            3'd1:    begin c_a = r_ux[2]; c_b = r_uy[1]; end
            3'd2:    begin c_a = r_ux[2]; c_b = r_uy[0]; end
            3'd3:    begin c_a = r_ux[0]; c_b = r_uy[2]; end
            3'd4:    begin c_a = r_ux[0]; c_b = r_uy[1]; end
            default: begin c_a = r_ux[1]; c_b = r_uy[0]; end
        endcase
    end
    assign c_prod = c_a * c_b;
    assign c_j    = r_cnt[2:0] - 3'd1;

    // Scale operands: Y by side radius, Z by up radius, X by axial offset
    always_comb begin
        if (r_cnt < 4'd3) begin
            s_vec = 2'd0;
        end else if (r_cnt < 4'd6) begin
            s_vec = 2'd1;
        end else begin
            s_vec = 2'd2;
        end
        case (r_cnt)
            4'd0, 4'd3, 4'd6: s_comp = 2'd0;
            4'd1, 4'd4, 4'd7: s_comp = 2'd1;
            default:          s_comp = 2'd2;
        endcase
        case (s_vec)
            2'd0: begin
                s_u = r_uy[s_comp];
                s_r = {2'b00, i_cfg.radius_side};
            end
            2'd1: begin
                s_u = r_uz[s_comp];
                s_r = {2'b00, i_cfg.radius_up};
            end
            default: begin
                s_u = r_ux[s_comp];
                s_r = {i_cfg.axial_offset[31], i_cfg.axial_offset};
            end
        endcase
        s_un    = 32'd0 - s_u;
        s_rn    = 33'd0 - s_r;
        s_ua    = s_u[31] ? s_un[30:0] : s_u[30:0];
        s_ra    = s_r[32] ? s_rn[31:0] : s_r[31:0];
        s_round = r_sprod + (63'd1 << 29);
        s_mag   = {1'b0, s_round[62:30]};
        s_val   = r_sneg ? (34'd0 - s_mag) : s_mag;
    end

    // Corner sum for the current corner, saturated per axis
    always_comb begin
        sy = (r_k == 2'd0) || (r_k == CORNER_LAST);
        sz = r_k[1];
        for (int i = 0; i < 3; i++) begin
            e_sum = {{4{r_p[i][31]}}, r_p[i]}
                  + (sy ? {{2{r_scl[i][33]}}, r_scl[i]}
                        : -{{2{r_scl[i][33]}}, r_scl[i]})
                  + (sz ? {{2{r_scl[3+i][33]}}, r_scl[3+i]}
                        : -{{2{r_scl[3+i][33]}}, r_scl[3+i]})
                  + {{2{r_scl[6+i][33]}}, r_scl[6+i]};
            corner[32*i +: 32] = sat32(e_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_start  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_start <= 1'b0;
            // Drop the output item once taken, unless a new corner replaces it
            if (i_m_axis_tready && (r_state != B_EMIT)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                // Take the next edge and unitize its direction
                B_IDLE: begin
                    if (!i_q_empty) begin
                        r_p    <= i_q_item.p;
                        r_join <= i_q_item.join_prev;
                        for (int i = 0; i < 3; i++) begin
                            r_uvec[i] <= {{(VW-DW){i_q_item.d[i][DW-1]}}, i_q_item.d[i]};
                        end
                        r_start <= 1'b1;
                        r_state <= B_UX;
                    end
                end
                B_UX: begin
                    if (i_u_done) begin
                        r_ux <= i_u_res;
                        if (is_general) begin
                            r_uvec[0] <= {VW{1'b0}} - {{(VW-CW){i_u_res[1][31]}}, i_u_res[1]};
                            r_uvec[1] <= {{(VW-CW){i_u_res[0][31]}}, i_u_res[0]};
                            r_uvec[2] <= '0;
                            r_start   <= 1'b1;
                            r_state   <= B_UY;
                        end else begin
                            r_uy    <= {32'd0, 32'd0, ONE_Q30};
                            r_uz    <= {32'd0, ONE_Q30, 32'd0};
                            r_cnt   <= '0;
                            r_state <= B_SCALE;
                        end
                    end
                end
                B_UY: begin
                    if (i_u_done) begin
                        r_uy    <= i_u_res;
                        r_cnt   <= '0;
                        r_state <= B_CROSS;
                    end
                end
                // Six products, paired into X cross Y
                B_CROSS: begin
                    if (r_cnt != 4'd6) begin
                        r_mprod <= c_prod;
                    end
                    if (r_cnt != 4'd0) begin
                        if (!c_j[0]) begin
                            r_w[c_j[2:1]] <= r_mprod[VW-1:0];
                        end else begin
                            r_w[c_j[2:1]] <= r_w[c_j[2:1]] - r_mprod[VW-1:0];
                        end
                    end
                    if (r_cnt == 4'd6) begin
                        r_uvec[0] <= r_w[0];
                        r_uvec[1] <= r_w[1];
                        r_uvec[2] <= r_w[2] - r_mprod[VW-1:0];
                        r_start   <= 1'b1;
                        r_state   <= B_UZ;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                B_UZ: begin
                    if (i_u_done) begin
                        r_uz    <= i_u_res;
                        r_cnt   <= '0;
                        r_state <= B_SCALE;
                    end
                end
                // Nine frame offsets through one multiplier
                B_SCALE: begin
                    if (r_cnt != 4'd9) begin
                        r_sprod <= s_ua * s_ra;
                        r_sneg  <= s_u[31] ^ s_r[32];
                    end
                    if (r_cnt != 4'd0) begin
                        r_scl[r_cnt - 4'd1] <= s_val;
                    end
                    if (r_cnt == 4'd9) begin
                        r_k     <= '0;
                        r_state <= B_EMIT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                // Hand out four corners through the output register
                B_EMIT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= corner;
                        r_ouser  <= {r_join, r_k};
                        r_olast  <= (r_k == CORNER_LAST);
                        r_k      <= r_k + 1'b1;
                        if (r_k == CORNER_LAST) begin
                            r_state <= B_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    a_last_on_corner3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_olast) |-> (r_ouser[1:0] == CORNER_LAST))
        else $error("last flag on a corner other than the fourth");

    a_corner_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_m_axis_tready && !r_olast)
        |=> (r_ovalid && (r_ouser[1:0] == $past(r_ouser[1:0]) + 2'd1)))
        else $error("corner sequence broken inside an edge");

    a_start_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |-> (r_state == B_UX || r_state == B_UY || r_state == B_UZ))
        else $error("unitizer started outside a wait state");

endmodule

`default_nettype wire

// ===== rtl/edge_tube_frame_corners.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                    Payload
// s_axis    in         i_s_axis_tvalid/o_..tready   tdata start xyz, end xyz; tuser first_edge
// m_axis    out        o_m_axis_tvalid/i_..tready   tdata corner xyz; tuser index, join; tlast
// cfg       in         i_cfg_valid/o_cfg_ready      i_cfg_index, i_cfg_data
//
// A zero-length edge ends each unitizer pass early. A direction near world Z takes
// one pass through the shared unitizer and any other direction takes three passes;
// a pass normalizes by single-bit shifts, then takes the square root and the three
// quotients. Nine frame offsets are then scaled and the four corners handed out.
// Reset is synchronous, active low; registers return to 0.1, 0.1 and 0.
// A two-entry edge queue lets intake continue while corners wait on a stalled output.

module edge_tube_frame_corners
    import etfc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [191:0] i_s_axis_tdata,   // start_x, start_y, start_z, end_x, end_y, end_z
    input  logic [0:0]   i_s_axis_tuser,   // first_edge
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [95:0]  o_m_axis_tdata,   // corner_x, corner_y, corner_z
    output logic [2:0]   o_m_axis_tuser,   // corner_index[1:0], joins_previous
    output logic         o_m_axis_tlast,   // last_corner
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    t_cfg  r_cfg;
    logic  q_full;
    logic  q_empty;
    logic  q_push;
    logic  q_pop;
    t_edge q_in;
    t_edge q_out;
    logic  u_start;
    t_wvec u_vec;
    logic  u_done;
    t_uvec u_res;

    assign o_cfg_ready = 1'b1;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radius_side  <= RADIUS_RESET;
            r_cfg.radius_up    <= RADIUS_RESET;
            r_cfg.axial_offset <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RADIUS_SIDE: r_cfg.radius_side  <= i_cfg_data[RW-1:0];
                CFG_RADIUS_UP:   r_cfg.radius_up    <= i_cfg_data[RW-1:0];
                CFG_AXIAL:       r_cfg.axial_offset <= i_cfg_data;
                default:         ;
            endcase
        end
    end

    etfc_front u_front (
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_q_full        (q_full),
        .o_q_push        (q_push),
        .o_q_item        (q_in)
    );

    etfc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_item  (q_out),
        .o_empty (q_empty)
    );

    etfc_unitize u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (u_start),
        .i_v     (u_vec),
        .o_done  (u_done),
        .o_u     (u_res)
    );

    etfc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_q_empty       (q_empty),
        .o_q_pop         (q_pop),
        .i_q_item        (q_out),
        .o_u_start       (u_start),
        .o_u_vec         (u_vec),
        .i_u_done        (u_done),
        .i_u_res         (u_res),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

`default_nettype wire

// ===== tb/edge_tube_frame_corners_tb.sv =====
`timescale 1ns / 1ps

module edge_tube_frame_corners_tb;
    import etfc_pkg::*;

    localparam int        HALF_PERIOD = 6;
    localparam int        IDLE_LIMIT  = 20000;
    localparam int        HOLD_OFF    = 3000;
    localparam int        SETTLE      = 600;
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int        NEAR_Z      = 32'h3FFF_FF80;

    typedef longint s64_vec_t [3];
    typedef int     q30_vec_t [3];

    typedef struct {
        int       x;
        int       y;
        int       z;
        bit [1:0] index;
        bit       join_prev;
        bit       last;
    } corner_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [191:0] i_s_axis_tdata = '0;
    logic [0:0]   i_s_axis_tuser = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [95:0]  o_m_axis_tdata;
    logic [2:0]   o_m_axis_tuser;
    logic         o_m_axis_tlast;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index = '0;
    logic [31:0]  i_cfg_data = '0;

    // Shadow registers
    logic [RW-1:0] side_reg;
    logic [RW-1:0] up_reg;
    int            axial_reg;

    corner_t corner_queue[$];
    int      fail_count = 0;
    int      next_gap = 0;
    bit      hold_request = 0;
    int      idle_cycles = 0;

    edge_tube_frame_corners dut (.*);

    always #HALF_PERIOD i_clk = ~i_clk;

    // Abort when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic longint unsigned isqrt_u64(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Normalize to Q2.30; zero stays zero
    function automatic q30_vec_t unitize(s64_vec_t v);
        longint unsigned mag[3];
        longint unsigned m, s, len, q;
        bit              neg[3];
        q30_vec_t        u;
        m = 0;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = v[i] < 0;
            mag[i] = neg[i] ? longint'(-v[i]) : longint'(v[i]);
            if (mag[i] > m) m = mag[i];
        end
        if (m == 0) begin
            u = '{0, 0, 0};
            return u;
        end
        while (m < (64'h1 << 30)) begin
            m <<= 1;
            for (int i = 0; i < 3; i++) mag[i] <<= 1;
        end
        while (m >= (64'h1 << 31)) begin
            m >>= 1;
            for (int i = 0; i < 3; i++) mag[i] >>= 1;
        end
        for (int i = 0; i < 3; i++) s += mag[i] * mag[i];
        len = isqrt_u64(s);
        for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << 30) + len / 2) / len;
            if (q > (64'h1 << 30)) q = 64'h1 << 30;
            u[i] = neg[i] ? -int'(q) : int'(q);
        end
        return u;
    endfunction

    // Q2.30 times Q16.16, rounded half away from zero
    function automatic longint scale_q30(int u, longint r);
        bit              neg;
        longint unsigned a, b, p;
        neg = (u < 0) != (r < 0);
        a = (u < 0) ? longint'(-longint'(u)) : longint'(u);
        b = (r < 0) ? longint'(-r) : longint'(r);
        p = (a * b + (64'h1 << 29)) >> 30;
        return neg ? -longint'(p) : longint'(p);
    endfunction

    function automatic int sat32(longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return int'(v);
    endfunction

    // Build the frame and queue the four corners of one edge
    function automatic void predict_corners(int st[3], int en[3], bit first);
        s64_vec_t d, w;
        q30_vec_t ux, uy, uz;
        longint   ry[3], rz[3], rx[3];
        longint   sy, sz;
        corner_t  c;
        for (int i = 0; i < 3; i++) d[i] = longint'(en[i]) - longint'(st[i]);
        ux = unitize(d);
        if (ux[2] > -NEAR_Z && ux[2] < NEAR_Z) begin
            w = '{-longint'(ux[1]), longint'(ux[0]), 0};
            uy = unitize(w);
            w[0] = longint'(ux[1]) * uy[2] - longint'(ux[2]) * uy[1];
            w[1] = longint'(ux[2]) * uy[0] - longint'(ux[0]) * uy[2];
            w[2] = longint'(ux[0]) * uy[1] - longint'(ux[1]) * uy[0];
            uz = unitize(w);
        end else begin
            uy = '{32'h4000_0000, 0, 0};
            uz = '{0, 32'h4000_0000, 0};
        end
        for (int i = 0; i < 3; i++) begin
            ry[i] = scale_q30(uy[i], longint'({33'b0, side_reg}));
            rz[i] = scale_q30(uz[i], longint'({33'b0, up_reg}));
            rx[i] = scale_q30(ux[i], longint'(axial_reg));
        end
        for (int k = 0; k < 4; k++) begin
            sy = (k == 0 || k == 3) ? 1 : -1;
            sz = (k >= 2) ? 1 : -1;
            c.x = sat32(st[0] + sy * ry[0] + sz * rz[0] + rx[0]);
            c.y = sat32(st[1] + sy * ry[1] + sz * rz[1] + rx[1]);
            c.z = sat32(st[2] + sy * ry[2] + sz * rz[2] + rx[2]);
            c.index = k[1:0];
            c.join_prev = !first;
            c.last = (k[1:0] == CORNER_LAST);
            corner_queue.push_back(c);
        end
    endfunction

    // Accept corners after a random stall, or a long hold-off on request
    initial begin : corner_sink
        int      stall;
        corner_t exp_c;
        forever begin
            if (hold_request) begin
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_OFF) @(posedge i_clk);
                hold_request = 0;
            end else begin
                stall = $urandom_range(0, 12);
                if (stall > 0) begin
                    i_m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_axis_tvalid) @(posedge i_clk);
            if (corner_queue.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected corner, got %h %h %0b", $time, o_m_axis_tdata,
                         o_m_axis_tuser, o_m_axis_tlast);
            end else begin
                exp_c = corner_queue.pop_front();
                if (o_m_axis_tdata[31:0] !== exp_c.x) begin
                    fail_count++;
                    $display("%0t: corner_x expected %h got %h", $time, exp_c.x,
                             o_m_axis_tdata[31:0]);
                end
                if (o_m_axis_tdata[63:32] !== exp_c.y) begin
                    fail_count++;
                    $display("%0t: corner_y expected %h got %h", $time, exp_c.y,
                             o_m_axis_tdata[63:32]);
                end
                if (o_m_axis_tdata[95:64] !== exp_c.z) begin
                    fail_count++;
                    $display("%0t: corner_z expected %h got %h", $time, exp_c.z,
                             o_m_axis_tdata[95:64]);
                end
                if (o_m_axis_tuser[1:0] !== exp_c.index) begin
                    fail_count++;
                    $display("%0t: corner_index expected %0d got %0d", $time, exp_c.index,
                             o_m_axis_tuser[1:0]);
                end
                if (o_m_axis_tuser[2] !== exp_c.join_prev) begin
                    fail_count++;
                    $display("%0t: joins_previous expected %0b got %0b", $time,
                             exp_c.join_prev, o_m_axis_tuser[2]);
                end
                if (o_m_axis_tlast !== exp_c.last) begin
                    fail_count++;
                    $display("%0t: last_corner expected %0b got %0b", $time, exp_c.last,
                             o_m_axis_tlast);
                end
            end
        end
    end

    // Offer one edge; keep valid high when the next gap is zero
    task automatic send_edge(int sx, int sy, int sz, int ex, int ey, int ez, bit first);
        int st[3];
        int en[3];
        st = '{sx, sy, sz};
        en = '{ex, ey, ez};
        repeat (next_gap) @(posedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {ez, ey, ex, sz, sy, sx};
        i_s_axis_tuser <= first;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_corners(st, en, first);
        next_gap = $urandom_range(0, 12);
        if (next_gap != 0) i_s_axis_tvalid <= 1'b0;
    endtask

    // Drop valid and wait for all corners to drain
    task automatic drain;
        if (next_gap == 0) i_s_axis_tvalid <= 1'b0;
        next_gap = 0;
        @(posedge i_clk);
        while (corner_queue.size() != 0) @(posedge i_clk);
    endtask

    // Write one register, then drop valid and let the channel idle
    task automatic write_reg(logic [1:0] index, logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (index)
            CFG_RADIUS_SIDE: side_reg = value[RW-1:0];
            CFG_RADIUS_UP:   up_reg = value[RW-1:0];
            CFG_AXIAL:       axial_reg = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_regs(logic [31:0] side, logic [31:0] up, logic [31:0] axial);
        write_reg(CFG_RADIUS_SIDE, side);
        write_reg(CFG_RADIUS_UP, up);
        write_reg(CFG_AXIAL, axial);
    endtask

    // One edge of a random kind
    task automatic random_edge(int sx, int sy, int sz, bit first, output int e[3]);
        case ($urandom_range(0, 7))
            0, 1:    e = '{$urandom, $urandom, $urandom};
            2:       e = '{sx + $urandom_range(0, 3) - 1, sy + $urandom_range(0, 3) - 1,
                           sz + (($urandom & 1) ? 1 : -1) * int'($urandom_range(1, 1 << 24))};
            3:       e = '{sx, sy, sz};
            default: e = '{sx + int'($urandom_range(0, 1 << 21)) - (1 << 20),
                           sy + int'($urandom_range(0, 1 << 21)) - (1 << 20),
                           sz + int'($urandom_range(0, 1 << 21)) - (1 << 20)};
        endcase
        send_edge(sx, sy, sz, e[0], e[1], e[2], first);
    endtask

    task automatic test_reset_defaults;
        send_edge(0, 0, 0, 32'h0001_0000, 0, 0, 1);
        send_edge(32'h0001_0000, 0, 0, 32'h0001_0000, 32'h0001_0000, 0, 0);
        send_edge(0, 0, 0, 0, 0, 32'h0001_0000, 0);
        drain();
    endtask

    task automatic test_directed_edges;
        int mx;
        int mn;
        mx = 32'h7FFF_FFFF;
        mn = 32'h8000_0000;
        set_regs(32'h0002_0000, 32'h0001_8000, 32'h0000_4000);
        send_edge(0, 0, 0, 0, 0, 0, 1);                      // zero length
        send_edge(5, 6, 7, 5, 6, 7 + (1 << 16), 0);          // straight up
        send_edge(5, 6, 7, 5, 6, 7 - (1 << 16), 0);          // straight down
        send_edge(0, 0, 0, 1, 0, 32'h0100_0000, 0);          // just inside near-parallel
        send_edge(0, 0, 0, 1 << 13, 0, 1 << 24, 0);          // still just inside it
        send_edge(0, 0, 0, 0, -(1 << 16), 0, 1);
        send_edge(mn, mn, mn, mx, mx, mx, 0);                // widest difference
        send_edge(mx, mx, mx, mn, mn, mn, 1);
        send_edge(mx, mn, mx, mn, mx, mn, 0);
        send_edge(mx, mx, mx, mx, mx, mx - 1, 0);
        send_edge(1, -1, 3, -7, 11, 2, 1);
        drain();
    endtask

    task automatic test_register_extremes;
        // Top bit of the radius writes must be dropped
        set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        send_edge(32'h7FFF_0000, 32'h7FFF_0000, 0, 0, 0, 0, 1);
        send_edge(32'h8000_0000, 0, 32'h8000_0000, 32'h8000_0100, 5, 32'h8000_0000, 0);
        send_edge(0, 0, 0, 0, 0, 0, 0);
        drain();
        set_regs(0, 0, 32'h8000_0000);
        send_edge(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 3, 4, 5, 1);
        send_edge(0, 0, 0, -(1 << 16), 1 << 16, 1 << 15, 0);
        drain();
        set_regs(32'h8000_0000, 32'h4000_0000, 32'hFFFF_0000);
        send_edge(32'h1234_5678, 32'hCAFE_0000, 0, 0, 0, 32'h4000_0000, 1);
        drain();
    endtask

    task automatic test_output_backpressure;
        int e[3];
        set_regs(32'd6554, 32'd13107, 32'h0000_8000);
        hold_request = 1;
        for (int n = 0; n < 10; n++) random_edge($urandom, $urandom, $urandom, n == 0, e);
        drain();
    endtask

    // Random paths: within a path, each edge starts where the previous ended
    task automatic test_random_paths(int count);
        int st[3];
        int e[3];
        int left;
        left = 0;
        for (int n = 0; n < count; n++) begin
            if (left == 0) begin
                left = $urandom_range(1, 12);
                st = '{$urandom, $urandom, $urandom};
                if ($urandom_range(0, 1)) st = '{st[0] >>> 8, st[1] >>> 8, st[2] >>> 8};
                random_edge(st[0], st[1], st[2], $urandom_range(0, 9) != 0, e);
            end else begin
                random_edge(st[0], st[1], st[2], $urandom_range(0, 9) == 0, e);
            end
            st = e;
            left--;
        end
        drain();
    endtask

    initial begin
        side_reg = RADIUS_RESET;
        up_reg = RADIUS_RESET;
        axial_reg = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_directed_edges();
        test_register_extremes();
        test_output_backpressure();
        set_regs($urandom & 32'h0003_FFFF, $urandom & 32'h0003_FFFF, $urandom);
        test_random_paths(90);
        set_regs($urandom, $urandom, $urandom);
        test_random_paths(60);
        set_regs(32'd6554, 32'd6554, 0);
        test_random_paths(90);

        repeat (SETTLE) @(posedge i_clk);
        if (corner_queue.size() != 0) begin
            fail_count++;
            $display("%0t: corners missing, expected %0d more got 0", $time,
                     corner_queue.size());
        end
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/etfc_pkg.sv
rtl/etfc_front.sv
rtl/etfc_queue.sv
rtl/etfc_unitize.sv
rtl/etfc_back.sv
rtl/edge_tube_frame_corners.sv
tb/edge_tube_frame_corners_tb.sv
